// ===== design/hba_pkg.sv =====
// Shared types and register codes for the hybrid burst assembler.
// Used by every module in the design folder; depends on nothing.
`timescale 1ns / 1ps

package hba_pkg;

   localparam int BYTES_W     = 16;
   localparam int ADDR_W      = 32;
   localparam int MAX_BYTES_W = 20;
   localparam int TOTAL_W     = 21;
   localparam int COUNT_W     = 16;
   localparam int TICKS_W     = 24;
   localparam int SEQ_W       = 32;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_IDX_W   = 1;

   localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = MAX_BYTES_W'(9000);
   localparam logic [TICKS_W-1:0]     TIMEOUT_RESET   = TICKS_W'(1000);
   localparam logic [COUNT_W-1:0]     COUNT_SAT       = {COUNT_W{1'b1}};

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BURST_BYTES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS   = 1'b1;

   // Item kinds and close causes.
   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_TICK    = 1'b1;
   localparam logic CAUSE_LENGTH = 1'b0;
   localparam logic CAUSE_TIMER  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTES_W-1:0] bytes;
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  dst;
   } item_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] bytes;
      logic [COUNT_W-1:0] packets;
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  dst;
      logic               cause;
      logic [SEQ_W-1:0]   number;
   } burst_type;

   typedef struct packed {
      logic      emit;
      burst_type burst;
   } result_type;

endpackage

// ===== design/hba_in_stage.sv =====
// Input register of the burst assembler: holds one accepted item.
// Depends on hba_pkg for the item type.
`timescale 1ns / 1ps

module hba_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hba_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output hba_pkg::item_type item
);
   import hba_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Take a new item when the register is empty or the held one moves on this cycle.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/hba_burst_core.sv =====
// Burst state, configuration registers and the per-item update.
// Depends on hba_pkg for item, result types and register codes.
`timescale 1ns / 1ps

module hba_burst_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              advance,
   input  hba_pkg::item_type                 item,
   output hba_pkg::result_type               result
);
   import hba_pkg::*;

   logic [MAX_BYTES_W-1:0] max_bytes_ff;
   logic [TICKS_W-1:0]     timeout_ff;

   logic               open_ff,       open_in;
   logic [TOTAL_W-1:0] total_ff,      total_in;
   logic [COUNT_W-1:0] count_ff,      count_in;
   logic [ADDR_W-1:0]  src_ff,        src_in;
   logic [ADDR_W-1:0]  dst_ff,        dst_in;
   logic [TICKS_W-1:0] ticks_ff,      ticks_in;
   logic [SEQ_W-1:0]   seq_ff,        seq_in;

   logic [TOTAL_W:0]   sum;
   logic               fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_BURST_BYTES: max_bytes_ff <= csr_wdata[MAX_BYTES_W-1:0];
            CSR_TIMEOUT_TICKS:   timeout_ff   <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   assign sum  = {1'b0, total_ff} + (TOTAL_W+1)'(item.bytes);
   assign fits = sum <= (TOTAL_W+1)'(max_bytes_ff);

   always_comb begin
      open_in  = open_ff;
      total_in = total_ff;
      count_in = count_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      ticks_in = ticks_ff;
      seq_in   = seq_ff;

      result.emit         = 1'b0;
      result.burst.bytes   = total_ff;
      result.burst.packets = count_ff;
      result.burst.src     = src_ff;
      result.burst.dst     = dst_ff;
      result.burst.cause   = CAUSE_LENGTH;
      result.burst.number  = seq_ff;

      if (item.kind == KIND_TICK) begin
         if (open_ff) begin
            if (ticks_ff <= TICKS_W'(1)) begin
               // Countdown expired: send and go empty.
               result.emit        = 1'b1;
               result.burst.cause = CAUSE_TIMER;
               seq_in   = seq_ff + SEQ_W'(1);
               open_in  = 1'b0;
               total_in = '0;
               count_in = '0;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_ff - TICKS_W'(1);
            end
         end
      end else if (open_ff && fits) begin
         total_in = sum[TOTAL_W-1:0];
         if (count_ff != COUNT_SAT) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else begin
         // Close any open burst on length, then open a new one with this packet.
         if (open_ff) begin
            result.emit        = 1'b1;
            result.burst.cause = CAUSE_LENGTH;
            seq_in = seq_ff + SEQ_W'(1);
         end
         open_in  = 1'b1;
         total_in = TOTAL_W'(item.bytes);
         count_in = COUNT_W'(1);
         src_in   = item.src;
         dst_in   = item.dst;
         ticks_in = timeout_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         total_ff <= '0;
         count_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         ticks_ff <= '0;
         seq_ff   <= '0;
      end else if (advance) begin
         open_ff  <= open_in;
         total_ff <= total_in;
         count_ff <= count_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         ticks_ff <= ticks_in;
         seq_ff   <= seq_in;
      end
   end

   a_empty_is_clear: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (total_ff == '0) && (count_ff == '0))
      else $error("empty burst holds a byte or packet total");

   a_open_has_packet: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> count_ff != '0)
      else $error("open burst with no packets");

   a_seq_steps: assert property (@(posedge clock) disable iff (reset)
      advance && result.emit |=> seq_ff == $past(seq_ff) + SEQ_W'(1))
      else $error("burst number did not advance on emit");

   a_tick_no_reopen: assert property (@(posedge clock) disable iff (reset)
      advance && item.kind == KIND_TICK && !open_ff |=> !open_ff)
      else $error("tick opened a burst");

endmodule

// ===== design/hba_out_stage.sv =====
// Result register of the burst assembler: holds one burst until taken.
// Depends on hba_pkg for the result types.
`timescale 1ns / 1ps

module hba_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  hba_pkg::result_type result,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hba_pkg::burst_type  rsp_burst
);
   import hba_pkg::*;

   logic      valid_ff;
   burst_type burst_ff;

   assign room = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance && result.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         burst_ff <= result.burst;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_burst = burst_ff;

endmodule

// ===== design/hybrid_burst_assembler_unit.sv =====
// Hybrid burst assembler: gathers packet items into bursts closed by length
// limit or by a tick countdown. One item is taken every cycle while results
// are taken as they appear. A burst descriptor appears on the rsp side after
// the item that closes it has passed the input register; it waits there until
// the result side has room, and the burst state and the result register then
// update together. A result that has not been taken holds every item behind
// it: the input register keeps its item, and once it holds one it takes no
// new one until the result goes.
// Depends on hba_pkg, hba_in_stage, hba_burst_core and hba_out_stage.
`timescale 1ns / 1ps

module hybrid_burst_assembler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [hba_pkg::BYTES_W-1:0]       req_pkt_bytes,
   input  logic [hba_pkg::ADDR_W-1:0]        req_pkt_src,
   input  logic [hba_pkg::ADDR_W-1:0]        req_pkt_dst,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hba_pkg::TOTAL_W-1:0]       rsp_burst_bytes,
   output logic [hba_pkg::COUNT_W-1:0]       rsp_burst_packets,
   output logic [hba_pkg::ADDR_W-1:0]        rsp_burst_src,
   output logic [hba_pkg::ADDR_W-1:0]        rsp_burst_dst,
   output logic                              rsp_close_cause,
   output logic [hba_pkg::SEQ_W-1:0]         rsp_burst_number
);
   import hba_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       room;
   logic       advance;
   result_type result;
   burst_type  rsp_burst;

   assign req_item.kind  = req_type;
   assign req_item.bytes = req_pkt_bytes;
   assign req_item.src   = req_pkt_src;
   assign req_item.dst   = req_pkt_dst;

   // Move the held item through the update only when the result side has room.
   assign advance = item_valid && room;

   hba_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hba_burst_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   hba_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_burst (rsp_burst)
   );

   assign rsp_burst_bytes   = rsp_burst.bytes;
   assign rsp_burst_packets = rsp_burst.packets;
   assign rsp_burst_src     = rsp_burst.src;
   assign rsp_burst_dst     = rsp_burst.dst;
   assign rsp_close_cause   = rsp_burst.cause;
   assign rsp_burst_number  = rsp_burst.number;

endmodule
